FILE: sv/hsv2rgb_pkg.sv
// shared constants and types for the hsv to rgb converter
package hsv2rgb_pkg;

   localparam int unsigned SectorSteps = 43;
   localparam int unsigned SatFull     = 254;
   localparam int unsigned PosScale    = 6;
   localparam int unsigned LastSector  = 5;

   // x / 254 computed as (x >> 1) * RecipMult >> RecipShift, exact for x < 65536
   localparam int unsigned RecipMult   = 33027;
   localparam int unsigned RecipShift  = 22;

   typedef enum logic [2:0] {
      SEC_RED_YEL = 3'd0,
      SEC_YEL_GRN = 3'd1,
      SEC_GRN_CYN = 3'd2,
      SEC_CYN_BLU = 3'd3,
      SEC_BLU_MAG = 3'd4,
      SEC_MAG_RED = 3'd5
   } sector_type;

   typedef struct packed {
      logic mul_en;
      logic div_en;
   } scale_ctl_type;

endpackage

FILE: sv/hsv2rgb_scale.sv
// two-stage v * k / 254 scaler with reciprocal multiply
module hsv2rgb_scale (
   input  logic                        clock,
   input  hsv2rgb_pkg::scale_ctl_type  ctl,
   input  logic [7:0]                  value,
   input  logic [7:0]                  factor,
   output logic [7:0]                  scaled
);
   import hsv2rgb_pkg::*;

   localparam int ProdW  = 16;
   localparam int RecipW = 16;
   localparam int WideW  = ProdW - 1 + RecipW;

   logic [ProdW-1:0] prod_ff;
   logic [ProdW-1:0] prod_in;
   logic [WideW-1:0] wide;
   logic [7:0]       quot_ff;
   logic [7:0]       quot_in;

   assign prod_in = ProdW'(value) * ProdW'(factor);
   assign wide    = WideW'(prod_ff[ProdW-1:1]) * WideW'(RecipMult);
   assign quot_in = wide[RecipShift +: 8];

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctl.div_en) begin
         quot_ff <= quot_in;
      end
   end

   assign scaled = quot_ff;

endmodule

FILE: sv/hsv_to_rgb_converter_top.sv
// hsv to rgb converter top level: five-stage pipeline with valid/ready handshake
// an accepted req word is registered in each stage in turn before it raises rsp_valid
// throughput: one word per cycle while rsp is not stalled, set by the fully pipelined multipliers
// a stalled rsp holds the pipeline in place; empty stages still fill
// reset clears all stage valid bits; data registers are not reset
module hsv_to_rgb_converter_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_hue,
   input  logic [7:0] req_saturation,
   input  logic [7:0] req_brightness,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue
);
   import hsv2rgb_pkg::*;

   localparam int Stages = 5;

   logic [Stages-1:0] val_ff;
   logic [Stages-1:0] val_in;
   logic [Stages-1:0] en;

   // stage 1: sector, position, clamped saturation
   sector_type sec1_ff, sec1_in;
   logic [7:0] pos1_ff, pos1_in;
   logic [7:0] sat1_ff, sat1_in;
   logic [7:0] v1_ff;
   logic [5:0] rem;

   // stage 2: scale factors for p, q, t
   sector_type sec2_ff;
   logic [7:0] v2_ff;
   logic [7:0] kp2_ff, kp2_in;
   logic [7:0] kq2_ff, kq2_in;
   logic [7:0] kt2_ff, kt2_in;
   logic [15:0] prod_q;
   logic [15:0] prod_t;

   // stages 3 and 4 live in the scalers
   sector_type sec3_ff, sec4_ff;
   logic [7:0] v3_ff, v4_ff;
   logic [7:0] p4, q4, t4;
   scale_ctl_type scale_ctl;

   // stage 5: output word
   logic [7:0] red_ff, red_in;
   logic [7:0] green_ff, green_in;
   logic [7:0] blue_ff, blue_in;

   // handshake: a stage advances when empty or when the next one advances
   always_comb begin
      en[Stages-1] = !val_ff[Stages-1] || rsp_ready;
      for (int i = Stages - 2; i >= 0; i--) begin
         en[i] = !val_ff[i] || en[i+1];
      end
      val_in[0] = en[0] ? req_valid : val_ff[0];
      for (int i = 1; i < Stages; i++) begin
         val_in[i] = en[i] ? val_ff[i-1] : val_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else begin
         val_ff <= val_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = val_ff[Stages-1];

   // stage 1 logic
   always_comb begin
      priority if (req_hue >= 8'(5 * SectorSteps)) begin
         sec1_in = SEC_MAG_RED;
         rem     = 6'(req_hue - 8'(5 * SectorSteps));
      end else if (req_hue >= 8'(4 * SectorSteps)) begin
         sec1_in = SEC_BLU_MAG;
         rem     = 6'(req_hue - 8'(4 * SectorSteps));
      end else if (req_hue >= 8'(3 * SectorSteps)) begin
         sec1_in = SEC_CYN_BLU;
         rem     = 6'(req_hue - 8'(3 * SectorSteps));
      end else if (req_hue >= 8'(2 * SectorSteps)) begin
         sec1_in = SEC_GRN_CYN;
         rem     = 6'(req_hue - 8'(2 * SectorSteps));
      end else if (req_hue >= 8'(SectorSteps)) begin
         sec1_in = SEC_YEL_GRN;
         rem     = 6'(req_hue - 8'(SectorSteps));
      end else begin
         sec1_in = SEC_RED_YEL;
         rem     = req_hue[5:0];
      end
      pos1_in = 8'(rem) * 8'(PosScale);
      sat1_in = (req_saturation > 8'(SatFull)) ? 8'(SatFull) : req_saturation;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         sec1_ff <= sec1_in;
         pos1_ff <= pos1_in;
         sat1_ff <= sat1_in;
         v1_ff   <= req_brightness;
      end
   end

   // stage 2 logic
   assign prod_q = 16'(sat1_ff) * 16'(pos1_ff);
   assign prod_t = 16'(sat1_ff) * 16'(8'(SatFull) - pos1_ff);
   assign kp2_in = 8'(SatFull) - sat1_ff;
   assign kq2_in = 8'(SatFull) - prod_q[15:8];
   assign kt2_in = 8'(SatFull) - prod_t[15:8];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         sec2_ff <= sec1_ff;
         v2_ff   <= v1_ff;
         kp2_ff  <= kp2_in;
         kq2_ff  <= kq2_in;
         kt2_ff  <= kt2_in;
      end
      if (en[2]) begin
         sec3_ff <= sec2_ff;
         v3_ff   <= v2_ff;
      end
      if (en[3]) begin
         sec4_ff <= sec3_ff;
         v4_ff   <= v3_ff;
      end
   end

   // stages 3 and 4: v * k / 254 for p, q, t
   assign scale_ctl.mul_en = en[2];
   assign scale_ctl.div_en = en[3];

   hsv2rgb_scale u_scale_p (
      .clock  (clock),
      .ctl    (scale_ctl),
      .value  (v2_ff),
      .factor (kp2_ff),
      .scaled (p4)
   );

   hsv2rgb_scale u_scale_q (
      .clock  (clock),
      .ctl    (scale_ctl),
      .value  (v2_ff),
      .factor (kq2_ff),
      .scaled (q4)
   );

   hsv2rgb_scale u_scale_t (
      .clock  (clock),
      .ctl    (scale_ctl),
      .value  (v2_ff),
      .factor (kt2_ff),
      .scaled (t4)
   );

   // stage 5: place v, p, q, t onto the channels
   always_comb begin
      unique case (sec4_ff)
         SEC_RED_YEL: begin
            red_in = v4_ff; green_in = t4;    blue_in = p4;
         end
         SEC_YEL_GRN: begin
            red_in = q4;    green_in = v4_ff; blue_in = p4;
         end
         SEC_GRN_CYN: begin
            red_in = p4;    green_in = v4_ff; blue_in = t4;
         end
         SEC_CYN_BLU: begin
            red_in = p4;    green_in = q4;    blue_in = v4_ff;
         end
         SEC_BLU_MAG: begin
            red_in = t4;    green_in = p4;    blue_in = v4_ff;
         end
         default: begin
            red_in = v4_ff; green_in = p4;    blue_in = q4;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

FILE: tb/tb_hsv_to_rgb_converter_top.sv
// self-checking testbench for the hsv to rgb converter: directed corners, random colors, stalls
module tb_hsv_to_rgb_converter_top;
   import hsv2rgb_pkg::*;

   localparam int unsigned CycleLimit  = 400000;
   localparam int unsigned RandomWords = 1050;
   localparam int unsigned DrainCycles = 20;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   class color_scoreboard;
      rgb_type expected_rgb[$];
      int      errors;

      function new();
         errors = 0;
      endfunction

      function rgb_type predict_rgb(logic [7:0] hue, logic [7:0] sat_in, logic [7:0] val);
         int unsigned h, s, v, idx, pos, p, q, t;
         sector_type  sec;
         rgb_type     rgb;
         h = hue;
         s = sat_in;
         v = val;
         if (s > SatFull) s = SatFull;
         if (s == 0) begin
            rgb = '{red: val, green: val, blue: val};
            return rgb;
         end
         idx = h / SectorSteps;
         if (idx > LastSector) idx = LastSector;
         sec = sector_type'(idx);
         pos = (h % SectorSteps) * PosScale;
         p = (v * (SatFull - s)) / SatFull;
         q = (v * (SatFull - ((s * pos) >> 8))) / SatFull;
         t = (v * (SatFull - ((s * (SatFull - pos)) >> 8))) / SatFull;
         case (sec)
            SEC_RED_YEL: rgb = '{red: v[7:0], green: t[7:0], blue: p[7:0]};
            SEC_YEL_GRN: rgb = '{red: q[7:0], green: v[7:0], blue: p[7:0]};
            SEC_GRN_CYN: rgb = '{red: p[7:0], green: v[7:0], blue: t[7:0]};
            SEC_CYN_BLU: rgb = '{red: p[7:0], green: q[7:0], blue: v[7:0]};
            SEC_BLU_MAG: rgb = '{red: t[7:0], green: p[7:0], blue: v[7:0]};
            default:     rgb = '{red: v[7:0], green: p[7:0], blue: q[7:0]};
         endcase
         return rgb;
      endfunction

      function void note_hsv(logic [7:0] hue, logic [7:0] sat_in, logic [7:0] val);
         expected_rgb.push_back(predict_rgb(hue, sat_in, val));
      endfunction

      function void check_rgb(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
         rgb_type exp_rgb;
         if (expected_rgb.size() == 0) begin
            $display("%0t: unexpected rsp word r=%0d g=%0d b=%0d", $time, red, green, blue);
            errors++;
            return;
         end
         exp_rgb = expected_rgb.pop_front();
         if (red !== exp_rgb.red) begin
            $display("%0t: red mismatch expected %0d actual %0d", $time, exp_rgb.red, red);
            errors++;
         end
         if (green !== exp_rgb.green) begin
            $display("%0t: green mismatch expected %0d actual %0d", $time, exp_rgb.green, green);
            errors++;
         end
         if (blue !== exp_rgb.blue) begin
            $display("%0t: blue mismatch expected %0d actual %0d", $time, exp_rgb.blue, blue);
            errors++;
         end
      endfunction

      function int pending();
         return expected_rgb.size();
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_hue;
   logic [7:0] req_saturation;
   logic [7:0] req_brightness;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_red;
   logic [7:0] rsp_green;
   logic [7:0] rsp_blue;

   color_scoreboard sb;
   bit              steady_flow;
   int unsigned     cycle_count = 0;

   // hue, saturation, brightness
   localparam logic [23:0] DirectedHsv[23] = '{
      {8'd0,   8'd254, 8'd255}, {8'd255, 8'd254, 8'd255}, {8'd255, 8'd255, 8'd255},
      {8'd0,   8'd0,   8'd0},   {8'd128, 8'd0,   8'd200}, {8'd255, 8'd0,   8'd255},
      {8'd42,  8'd254, 8'd255}, {8'd43,  8'd254, 8'd255}, {8'd85,  8'd254, 8'd255},
      {8'd86,  8'd254, 8'd255}, {8'd128, 8'd254, 8'd255}, {8'd129, 8'd254, 8'd255},
      {8'd171, 8'd254, 8'd255}, {8'd172, 8'd254, 8'd255}, {8'd214, 8'd254, 8'd255},
      {8'd215, 8'd254, 8'd255}, {8'd254, 8'd254, 8'd255}, {8'd100, 8'd255, 8'd128},
      {8'd21,  8'd1,   8'd255}, {8'd200, 8'd128, 8'd1},   {8'd170, 8'd127, 8'd255},
      {8'd77,  8'd254, 8'd0},   {8'd240, 8'd255, 8'd85}
   };

   hsv_to_rgb_converter_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (steady_flow) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_hsv(input logic [7:0] hue, input logic [7:0] sat_in,
                           input logic [7:0] val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_hue        <= hue;
      req_saturation <= sat_in;
      req_brightness <= val;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [7:0] random_saturation();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 8'd0;
      if (r == 1) return 8'd255;
      if (r == 2) return 8'd254;
      return 8'($urandom_range(0, 254));
   endfunction

   function automatic logic [7:0] random_brightness();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 8'd0;
      if (r == 1) return 8'd255;
      return 8'($urandom_range(0, 255));
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_hsv(req_hue, req_saturation, req_brightness);
         if (rsp_valid && rsp_ready) sb.check_rgb(rsp_red, rsp_green, rsp_blue);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver stalls
   initial begin
      int run;
      int stall;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if (steady_flow) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            run = $urandom_range(1, 12);
            repeat (run) @(posedge clock);
            stall = pick_gap();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
      end
   end

   initial begin
      sb             = new();
      steady_flow    = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_hue        = '0;
      req_saturation = '0;
      req_brightness = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DirectedHsv[i])
         send_hsv(DirectedHsv[i][23:16], DirectedHsv[i][15:8], DirectedHsv[i][7:0]);

      for (int n = 0; n < RandomWords; n++) begin
         if (n % 150 == 0) steady_flow = ($urandom_range(0, 2) == 0);
         send_hsv(8'($urandom_range(0, 255)), random_saturation(), random_brightness());
      end
      req_valid   <= 1'b0;
      steady_flow = 1'b0;

      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
sv/hsv2rgb_pkg.sv
sv/hsv2rgb_scale.sv
sv/hsv_to_rgb_converter_top.sv
tb/tb_hsv_to_rgb_converter_top.sv
